// ----- src/bst_pkg.sv -----
// Shared types, codes and constants of the breakpoint slot table.
package bst_pkg;

   localparam int SLOTS_DEFAULT = 128;
   localparam int ADDR_W        = 32;
   localparam int SLOT_W        = 7;
   localparam int WORD_W        = 32;

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_SEARCH = 2'd1,
      OP_ADD    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the accepted item and restart the scan
      logic clear_wr;  // write one zero entry of the clearing pass
      logic scan;      // issue the next slot read of a scan
      logic finish;    // apply the write, if any, and load the result register
   } bst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_scan;    // the offered item needs a scan of the table
      logic clear_last;  // the clearing pass writes its last entry now
      logic scan_last;   // the last slot of a scan is being evaluated now
      logic rsp_free;    // the result register can take a new item
   } bst_stat_type;

endpackage

// ----- src/bst_if.sv -----
// Valid/ready channel interfaces for the request and response items.
interface bst_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic [bst_pkg::ADDR_W-1:0]   address;
   logic [bst_pkg::SLOT_W-1:0]   slot_index;
   logic [bst_pkg::WORD_W-1:0]   saved_word;
   logic                         kind;

   modport source (output valid, output op, output address, output slot_index,
                   output saved_word, output kind, input ready);
   modport sink   (input valid, input op, input address, input slot_index,
                   input saved_word, input kind, output ready);
endinterface

interface bst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bst_pkg::SLOT_W-1:0]   slot;
   logic                         hit;

   modport source (output valid, output slot, output hit, input ready);
   modport sink   (input valid, input slot, input hit, output ready);
endinterface

// ----- src/bst_controller.sv -----
// Controller state machine of the breakpoint slot table.
module bst_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output bst_pkg::bst_cmd_type  cmd,
   input  bst_pkg::bst_stat_type stat
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = stat.req_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/bst_datapath.sv -----
// Datapath of the breakpoint slot table: slot memories, scan and result register.
module bst_datapath #(
   parameter int SLOTS = bst_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bst_pkg::bst_cmd_type          cmd,
   output bst_pkg::bst_stat_type         stat,
   input  logic [1:0]                    req_op,
   input  logic [bst_pkg::ADDR_W-1:0]    req_address,
   input  logic [bst_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic [bst_pkg::WORD_W-1:0]    req_saved_word,
   input  logic                          req_kind,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bst_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_hit
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int PTR_W = $clog2(SLOTS + 1);
   localparam logic [PTR_W-1:0] PTR_END   = PTR_W'(SLOTS);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
   localparam int TAG_W = bst_pkg::ADDR_W + 1;

   // Each tag word holds the used mark above the address.
   logic [TAG_W-1:0]            tag_mem   [SLOTS];
   logic [bst_pkg::WORD_W-1:0]  saved_mem [SLOTS];
   logic                        kind_mem  [SLOTS];

   bst_pkg::op_type             op_ff;
   logic [bst_pkg::ADDR_W-1:0]  addr_ff;
   logic [bst_pkg::SLOT_W-1:0]  idx_ff;
   logic [bst_pkg::WORD_W-1:0]  saved_ff;
   logic                        kind_ff;
   logic                        in_range_ff;

   logic [PTR_W-1:0]            ptr_ff;
   logic [PTR_W-1:0]            ptr_in;
   logic                        issue;
   logic                        data_valid_ff;
   logic [IDX_W-1:0]            data_tag_ff;
   logic [TAG_W-1:0]            rd_data_ff;

   logic                        match_any_ff;
   logic                        found_used_ff;
   logic [IDX_W-1:0]            found_idx_ff;
   logic                        free_found_ff;
   logic [IDX_W-1:0]            free_idx_ff;

   logic                        rsp_valid_ff;
   logic [bst_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic                        rsp_hit_ff;

   logic                        is_write_op;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   logic [TAG_W-1:0]            wr_data;
   logic                        eq;
   logic                        used;
   logic                        res_hit;
   logic [bst_pkg::SLOT_W-1:0]  res_slot;

   assign issue = cmd.scan && (ptr_ff != PTR_END);

   always_comb begin
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.clear_wr || issue) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   assign stat.req_scan   = (req_op == bst_pkg::OP_CHECK) || (req_op == bst_pkg::OP_SEARCH);
   assign stat.clear_last = cmd.clear_wr && (ptr_ff == PTR_LAST);
   assign stat.scan_last  = data_valid_ff && (data_tag_ff == IDX_LAST);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         data_valid_ff <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         data_valid_ff <= issue;
      end
   end

   // Captured item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= bst_pkg::op_type'(req_op);
         addr_ff     <= req_address;
         idx_ff      <= req_slot_index;
         saved_ff    <= req_saved_word;
         kind_ff     <= req_kind;
         in_range_ff <= (32'(req_slot_index) < 32'(SLOTS));
      end
   end

   // Single write port, shared by the clearing pass and add/remove.
   assign is_write_op = (op_ff == bst_pkg::OP_ADD) || (op_ff == bst_pkg::OP_REMOVE);
   assign wr_en   = cmd.clear_wr || (cmd.finish && in_range_ff && is_write_op);
   assign wr_idx  = cmd.clear_wr ? ptr_ff[IDX_W-1:0] : IDX_W'(idx_ff);
   assign wr_data = (!cmd.clear_wr && op_ff == bst_pkg::OP_ADD) ? {1'b1, addr_ff} : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_idx] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= tag_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && in_range_ff) begin
         if (op_ff == bst_pkg::OP_ADD) begin
            saved_mem[IDX_W'(idx_ff)] <= saved_ff;
            kind_mem[IDX_W'(idx_ff)]  <= kind_ff;
         end else if (op_ff == bst_pkg::OP_REMOVE) begin
            saved_mem[IDX_W'(idx_ff)] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         data_tag_ff <= ptr_ff[IDX_W-1:0];
      end
   end

   // Scan evaluation, one slot per cycle from slot zero upward.
   assign used = rd_data_ff[TAG_W-1];
   assign eq   = (rd_data_ff[bst_pkg::ADDR_W-1:0] == addr_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         match_any_ff  <= 1'b0;
         found_used_ff <= 1'b0;
         free_found_ff <= 1'b0;
         found_idx_ff  <= '0;
         free_idx_ff   <= '0;
      end else if (data_valid_ff) begin
         if (eq) begin
            match_any_ff <= 1'b1;
         end
         if (used && eq && !found_used_ff) begin
            found_used_ff <= 1'b1;
            found_idx_ff  <= data_tag_ff;
         end
         if (!used && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= data_tag_ff;
         end
      end
   end

   always_comb begin
      unique case (op_ff) inside
         bst_pkg::OP_CHECK: begin
            res_hit  = !match_any_ff && free_found_ff;
            res_slot = bst_pkg::SLOT_W'(free_idx_ff);
         end
         bst_pkg::OP_SEARCH: begin
            res_hit  = found_used_ff;
            res_slot = bst_pkg::SLOT_W'(found_idx_ff);
         end
         bst_pkg::OP_ADD, bst_pkg::OP_REMOVE: begin
            res_hit  = in_range_ff;
            res_slot = idx_ff;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit_ff  <= res_hit;
         rsp_slot_ff <= res_hit ? res_slot : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

// ----- src/breakpoint_slot_table.sv -----
// Top level of the breakpoint slot table: controller, datapath and channels.
//
// The table keeps SLOTS breakpoint slots, each with an address, a used mark, a
// saved code word and a kind, in on-chip memories with one write port and one
// registered read port. After reset a clearing pass writes every slot's address
// and used mark to zero, one slot per cycle, so the block accepts no item until
// that pass is over. A request item carries one of four operations. Check
// scans all slots and answers with the first free slot, or a miss when any
// slot (free slots included, whose address reads as zero) already holds the
// address or when the table is full. Search scans all slots and answers with
// the first used slot holding the address. Add stores address, saved word and
// kind into the given slot and marks it used; remove frees the slot and zeroes
// its address and saved word. Add and remove to a slot number at or above
// SLOTS change nothing and answer a miss. A response item always reports slot
// zero when hit is low. Items are handled one at a time: check and search
// read the tag memory once per slot and evaluate each registered read word
// before the result is formed; add and remove go straight to that final
// step, which waits for a free output register. The response sits in that
// register, so the next request is taken while a finished response still waits.
module breakpoint_slot_table #(
   parameter int SLOTS = bst_pkg::SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bst_req_if.sink    req,
   bst_rsp_if.source  rsp
);

   bst_pkg::bst_cmd_type  cmd;
   bst_pkg::bst_stat_type stat;

   // The controller sequences the clearing pass, the scan and the final write.
   bst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the slot memories, the scan flags and the result item.
   bst_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req.op),
      .req_address    (req.address),
      .req_slot_index (req.slot_index),
      .req_saved_word (req.saved_word),
      .req_kind       (req.kind),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_slot       (rsp.slot),
      .rsp_hit        (rsp.hit)
   );

endmodule

// ----- src/bst_checker.sv -----
// Port-level assertions of the breakpoint slot table, bound to the top level.
module bst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bst_pkg::SLOT_W-1:0]  rsp_slot,
   input logic                        rsp_hit
);

   logic [1:0] pend_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Items taken in and not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         pend_ff <= pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_ff <= pend_ff - 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit))
      else $error("stalled response item changed or dropped");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_slot == '0)
      else $error("missed response item reports a nonzero slot");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while the previous item is still at work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response item without an outstanding request item");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two items outstanding");

endmodule

bind breakpoint_slot_table bst_checker u_bst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_slot  (rsp.slot),
   .rsp_hit   (rsp.hit)
);

// ----- bench/tb_breakpoint_slot_table.sv -----
// Self-checking testbench for the breakpoint slot table with its own prediction of every answer.
`timescale 1ns / 1ps

module tb_breakpoint_slot_table;

   // The block is built with its default size, so every slot number that the
   // seven-bit slot field can carry names a real slot.
   localparam int TABLE_SLOTS = bst_pkg::SLOTS_DEFAULT;

   // Requests past this count end the random traffic.
   localparam int TOTAL_REQUESTS = 1600;

   // One request item and one answer item, at the widths of the channels.
   typedef struct packed {
      bst_pkg::op_type                op;
      logic [bst_pkg::ADDR_W-1:0]     address;
      logic [bst_pkg::SLOT_W-1:0]     slot_index;
      logic [bst_pkg::WORD_W-1:0]     saved_word;
      logic                           kind;
   } bp_request_type;

   typedef struct packed {
      logic [bst_pkg::SLOT_W-1:0]     slot;
      logic                           hit;
   } bp_answer_type;

   logic clock = 1'b0;
   logic reset;

   bst_req_if req_ch ();
   bst_rsp_if rsp_ch ();

   breakpoint_slot_table #(
      .SLOTS (TABLE_SLOTS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Free-running clock with a 2 ns period.
   always #1 clock = ~clock;

   // The testbench keeps its own copy of the table. The saved word and the
   // kind never reach an answer, but they are kept so that the copy mirrors
   // every field the block stores.
   logic [bst_pkg::ADDR_W-1:0] slot_address [TABLE_SLOTS];
   logic                       slot_used    [TABLE_SLOTS];
   logic [bst_pkg::WORD_W-1:0] slot_saved   [TABLE_SLOTS];
   logic                       slot_kind    [TABLE_SLOTS];

   // This queue holds the answers that are still to come, oldest first.
   bp_answer_type answers_due [$];

   // A few recurring addresses. They make searches hit and checks find
   // duplicates far more often than fresh 32-bit values would.
   logic [bst_pkg::ADDR_W-1:0] address_pool [16];

   int          mismatches = 0;
   int          requests_sent = 0;
   bit          quiet = 1'b0;            // when set, neither side idles
   int unsigned rsp_hold_request = 0;    // cycles the receiver should hold ready low

   // This function gives the answer that the table owes for a request, based
   // on the current contents. It does not change the table. A scan visits the
   // slots from 0 upward, so the loops that pick a slot run downward and the
   // lowest matching slot is the one that is kept.
   function automatic bp_answer_type table_answer(input bp_request_type rq);
      bp_answer_type ans;
      bit            taken;
      int            s;
      ans = '0;
      case (rq.op)
         bst_pkg::OP_CHECK: begin
            // Any slot that holds the address blocks the check. A free slot
            // counts too, because its address was cleared to zero.
            taken = 1'b0;
            for (s = 0; s < TABLE_SLOTS; s++)
               if (slot_address[s] == rq.address) taken = 1'b1;
            if (!taken) begin
               for (s = TABLE_SLOTS - 1; s >= 0; s--)
                  if (!slot_used[s]) ans = '{slot: s[bst_pkg::SLOT_W-1:0], hit: 1'b1};
            end
         end
         bst_pkg::OP_SEARCH: begin
            for (s = TABLE_SLOTS - 1; s >= 0; s--)
               if (slot_used[s] && slot_address[s] == rq.address)
                  ans = '{slot: s[bst_pkg::SLOT_W-1:0], hit: 1'b1};
         end
         default: begin
            // Add and remove always succeed on a slot that exists.
            if (int'(rq.slot_index) < TABLE_SLOTS) ans = '{slot: rq.slot_index, hit: 1'b1};
         end
      endcase
      return ans;
   endfunction

   // This function applies the effect of an accepted request to the table copy.
   function automatic void table_update(input bp_request_type rq);
      if (int'(rq.slot_index) >= TABLE_SLOTS) return;
      if (rq.op == bst_pkg::OP_ADD) begin
         slot_address[rq.slot_index] = rq.address;
         slot_saved[rq.slot_index]   = rq.saved_word;
         slot_kind[rq.slot_index]    = rq.kind;
         slot_used[rq.slot_index]    = 1'b1;
      end else if (rq.op == bst_pkg::OP_REMOVE) begin
         // The kind of the slot is left as it was.
         slot_address[rq.slot_index] = '0;
         slot_saved[rq.slot_index]   = '0;
         slot_used[rq.slot_index]    = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // This task offers one request item and returns once the block has taken
   // it. It is entered and left at a falling edge. A random gap may come first.
   // The valid signal is lowered only inside such a gap, or by a drain, so it
   // is never lowered and raised again within the same time step.
   task automatic send_item(input bst_pkg::op_type op,
                            input logic [bst_pkg::ADDR_W-1:0] address,
                            input logic [bst_pkg::SLOT_W-1:0] slot_index,
                            input logic [bst_pkg::WORD_W-1:0] saved_word,
                            input logic kind);
      bp_request_type rq;
      rq = '{op: op, address: address, slot_index: slot_index,
             saved_word: saved_word, kind: kind};
      while (!quiet && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= rq.op;
      req_ch.address    <= rq.address;
      req_ch.slot_index <= rq.slot_index;
      req_ch.saved_word <= rq.saved_word;
      req_ch.kind       <= rq.kind;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // The item was taken at this edge. The answer is predicted against the
      // table as it stood before this request.
      answers_due.push_back(table_answer(rq));
      table_update(rq);
      requests_sent++;
      @(negedge clock);
   endtask

   // This task stops offering items and waits until every predicted answer has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (answers_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [bst_pkg::ADDR_W-1:0] pick_address();
      return ($urandom_range(1) == 0) ? address_pool[$urandom_range(15)]
                                      : bst_pkg::ADDR_W'($urandom);
   endfunction

   // This function returns a used slot found from a random starting point, or -1 when the table is empty.
   function automatic int pick_used_slot();
      int start;
      int k;
      start = $urandom_range(TABLE_SLOTS - 1);
      for (k = 0; k < TABLE_SLOTS; k++)
         if (slot_used[(start + k) % TABLE_SLOTS]) return (start + k) % TABLE_SLOTS;
      return -1;
   endfunction

   // This task sets a breakpoint the way a debugger does: it checks for a free
   // slot, adds the breakpoint there if the check succeeds, and then searches
   // for the address.
   task automatic set_breakpoint(input logic [bst_pkg::ADDR_W-1:0] address);
      bp_answer_type  ans;
      bp_request_type probe;
      probe = '{op: bst_pkg::OP_CHECK, address: address, slot_index: '0,
                saved_word: '0, kind: 1'b0};
      ans = table_answer(probe);
      send_item(bst_pkg::OP_CHECK, address, bst_pkg::SLOT_W'($urandom),
                bst_pkg::WORD_W'($urandom), 1'($urandom));
      if (ans.hit)
         send_item(bst_pkg::OP_ADD, address, ans.slot, bst_pkg::WORD_W'($urandom),
                   1'($urandom));
      send_item(bst_pkg::OP_SEARCH, address, bst_pkg::SLOT_W'($urandom),
                bst_pkg::WORD_W'($urandom), 1'($urandom));
   endtask

   task automatic send_noise();
      send_item(bst_pkg::op_type'($urandom_range(3)), pick_address(),
                bst_pkg::SLOT_W'($urandom), bst_pkg::WORD_W'($urandom), 1'($urandom));
   endtask

   // Directed test: the table just after reset. A check for address zero
   // misses, because every free slot reads as zero. A check for any other
   // address gets slot 0. No search can hit.
   task automatic test_empty_table();
      send_item(bst_pkg::OP_CHECK,  '0, '0, '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  '1, '1, '1, 1'b1);
      send_item(bst_pkg::OP_SEARCH, '0, '0, '0, 1'b0);
      send_item(bst_pkg::OP_SEARCH, '1, '1, '1, 1'b1);
   endtask

   // Directed test: adds at both ends of the table, checks for a duplicate,
   // a stored address of zero, the same address in two slots, and an add
   // that overwrites a used slot.
   task automatic test_add_and_search();
      send_item(bst_pkg::OP_ADD,    '1,            7'd127, '1, 1'b1);
      send_item(bst_pkg::OP_ADD,    32'h1,         7'd0,   '0, 1'b0);
      send_item(bst_pkg::OP_SEARCH, '1,            '0,     '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  '1,            '0,     '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  32'h2,         '0,     '0, 1'b0);
      send_item(bst_pkg::OP_ADD,    '0,            7'd1,   32'h5555_5555, 1'b1);
      send_item(bst_pkg::OP_SEARCH, '0,            '0,     '0, 1'b0);
      send_item(bst_pkg::OP_ADD,    32'h1,         7'd3,   32'hAAAA_AAAA, 1'b0);
      send_item(bst_pkg::OP_ADD,    32'h8000_0000, 7'd0,   '1, 1'b1);
      send_item(bst_pkg::OP_SEARCH, 32'h1,         '0,     '0, 1'b0);
   endtask

   // Directed test: removes, including a second remove of a slot that is already free.
   task automatic test_remove();
      send_item(bst_pkg::OP_REMOVE, '0, 7'd127, '0, 1'b0);
      send_item(bst_pkg::OP_SEARCH, '1, '0,     '0, 1'b0);
      send_item(bst_pkg::OP_REMOVE, '1, 7'd127, '1, 1'b1);
      send_item(bst_pkg::OP_REMOVE, '0, 7'd1,   '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  '0, '0,     '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  '1, '0,     '0, 1'b0);
   endtask

   // Backpressure test: the receiver holds ready low for a long stretch while
   // short add and remove items keep coming. The output register and the
   // block fill up, and the block must stall its input without losing an
   // answer. After that the sender waits until every answer is back.
   task automatic test_backpressure();
      int k;
      rsp_hold_request = 400;
      wait (rsp_hold_request == 0);
      for (k = 0; k < 12; k++)
         send_item((k % 3 == 2) ? bst_pkg::OP_REMOVE : bst_pkg::OP_ADD, pick_address(),
                   bst_pkg::SLOT_W'($urandom), bst_pkg::WORD_W'($urandom), 1'($urandom));
      wait_drained();
   endtask

   // Full-table test: breakpoints are set until every slot is used, with no
   // idling on either side. When the table is full, a check misses even for
   // a new address. After one slot is freed, a check must return that slot.
   task automatic test_full_table();
      int s;
      quiet = 1'b1;
      while (!(slot_used.and() == 1'b1))
         set_breakpoint(bst_pkg::ADDR_W'($urandom));
      send_item(bst_pkg::OP_CHECK,  bst_pkg::ADDR_W'($urandom), '0, '0, 1'b0);
      send_item(bst_pkg::OP_CHECK,  slot_address[TABLE_SLOTS - 1], '0, '0, 1'b0);
      send_item(bst_pkg::OP_SEARCH, slot_address[TABLE_SLOTS - 1], '0, '0, 1'b0);
      s = $urandom_range(TABLE_SLOTS - 1);
      send_item(bst_pkg::OP_REMOVE, pick_address(), s[bst_pkg::SLOT_W-1:0],
                bst_pkg::WORD_W'($urandom), 1'($urandom));
      set_breakpoint(bst_pkg::ADDR_W'($urandom));
      quiet = 1'b0;
   endtask

   // Random traffic. Most of it is the debugger's own pattern of setting,
   // finding and clearing breakpoints, with random content. The rest is noise
   // with any operation and any field values. Phases of about 300 items
   // alternate between filling and draining, so the table passes through
   // nearly empty and nearly full states.
   task automatic test_random_traffic();
      int r;
      int s;
      int set_pct;
      logic [bst_pkg::ADDR_W-1:0] a;
      while (requests_sent < TOTAL_REQUESTS) begin
         set_pct = ((requests_sent / 300) % 2 == 0) ? 40 : 10;
         r = $urandom_range(99);
         s = pick_used_slot();
         if (r < set_pct) begin
            set_breakpoint(pick_address());
         end else if (r < 50 && s >= 0) begin
            // Clear a live breakpoint: find it, free its slot, and sometimes search again.
            a = slot_address[s];
            send_item(bst_pkg::OP_SEARCH, a, bst_pkg::SLOT_W'($urandom),
                      bst_pkg::WORD_W'($urandom), 1'($urandom));
            send_item(bst_pkg::OP_REMOVE, pick_address(), s[bst_pkg::SLOT_W-1:0],
                      bst_pkg::WORD_W'($urandom), 1'($urandom));
            if ($urandom_range(1) == 1)
               send_item(bst_pkg::OP_SEARCH, a, bst_pkg::SLOT_W'($urandom),
                         bst_pkg::WORD_W'($urandom), 1'($urandom));
         end else if (r < 65 && s >= 0) begin
            send_item(bst_pkg::OP_SEARCH, slot_address[s], bst_pkg::SLOT_W'($urandom),
                      bst_pkg::WORD_W'($urandom), 1'($urandom));
         end else begin
            send_noise();
         end
      end
   endtask

   // The receiver drives ready at every falling edge. It idles at random,
   // except while quiet is set, and holds ready low for a requested stretch.
   // It counts that stretch itself.
   initial begin : answer_receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(99) >= 16);
         end
      end
   end

   // Each answer item taken at a rising edge is compared with the oldest prediction.
   always @(posedge clock) begin : answer_checker
      bp_answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("answer slot %0d hit %0b with no request pending",
                                      rsp_ch.slot, rsp_ch.hit));
         end else begin
            want = answers_due.pop_front();
            if (rsp_ch.hit !== want.hit)
               report_mismatch($sformatf("hit %0b, expected %0b", rsp_ch.hit, want.hit));
            if (rsp_ch.slot !== want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", rsp_ch.slot, want.slot));
         end
      end
   end

   // This block stops a run that hangs. It allows several times the slowest
   // correct run, including the clearing pass after reset.
   initial begin : watchdog
      #2_000_000;
      $display("** breakpoint_slot_table: FAILED **");
      $finish;
   end

   initial begin : test_sequence
      int k;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.op          = bst_pkg::OP_CHECK;
      req_ch.address     = '0;
      req_ch.slot_index  = '0;
      req_ch.saved_word  = '0;
      req_ch.kind        = 1'b0;
      for (k = 0; k < TABLE_SLOTS; k++) begin
         slot_address[k] = '0;
         slot_used[k]    = 1'b0;
         slot_saved[k]   = '0;
         slot_kind[k]    = 1'b0;
      end
      address_pool[0] = '0;
      address_pool[1] = '1;
      for (k = 2; k < 16; k++) address_pool[k] = bst_pkg::ADDR_W'($urandom);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The block clears its table after reset. The first send simply waits
      // for ready.
      test_empty_table();
      test_add_and_search();
      test_remove();
      test_backpressure();
      test_full_table();
      test_random_traffic();

      // Let every answer arrive. Then keep running for longer than a scan takes,
      // so that a stray extra answer would still be caught.
      wait_drained();
      repeat (TABLE_SLOTS + 8) @(negedge clock);
      if (mismatches == 0) begin
         $display("** breakpoint_slot_table: PASSED **");
      end else begin
         $display("** breakpoint_slot_table: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bst_pkg.sv
src/bst_if.sv
src/bst_controller.sv
src/bst_datapath.sv
src/breakpoint_slot_table.sv
src/bst_checker.sv
bench/tb_breakpoint_slot_table.sv
